/* hdl/open_addressing_hash_table_core_assert.svh */
// Assertion macros for the hash table core.
`ifndef OPEN_ADDRESSING_HASH_TABLE_CORE_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_TABLE_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define OAHT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication with the consequent checked in the next cycle.
`define OAHT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* hdl/oaht_pkg.sv */
// Shared types and constants for the hash table core.
package oaht_pkg;
  localparam int unsigned MaxSlotsDefault = 4096;
  localparam logic [12:0] SizeReset = 13'd2531;
  localparam int unsigned KeyW = 31;
  localparam int unsigned ValW = 32;
  localparam int unsigned CntW = 13;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NFOUND = 2'd1,
    ST_DUP    = 2'd2,
    ST_GROW   = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input item, start home-slot modulo
    logic mod_step;  // one restoring-division step
    logic rd;        // issue memory read at current slot
    logic adv;       // advance probe
    logic wr;        // write key/value at current slot
    logic clr_step;  // clear one valid bit
    logic clr_start;
    logic fin;       // build result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mod_done;
    logic hit;       // slot valid and key matches
    logic empty;     // slot not valid
    logic exhaust;   // collision count reached the size
    logic clr_done;
    logic can_ins;
  } sts_t;
endpackage

/* hdl/oaht_ctrl.sv */
// Controller state machine for the hash table core.
module oaht_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_fire_i,
  input  logic [1:0]    op_i,
  input  logic          out_free_i,
  input  oaht_pkg::sts_t sts_i,
  output oaht_pkg::cmd_t cmd_o,
  output logic          busy_o,
  output logic          res_valid_o
);
  import oaht_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b0_0000_0001,
    S_MOD  = 9'b0_0000_0010,
    S_RD   = 9'b0_0000_0100,
    S_CHK  = 9'b0_0000_1000,
    S_CLR  = 9'b0_0001_0000,
    S_FIN  = 9'b0_0010_0000,
    S_OUT  = 9'b0_0100_0000,
    S_WR   = 9'b0_1000_0000,
    S_INIT = 9'b1_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      op_q <= OP_NOP;
    end else begin
      state_q <= state_d;
      if (in_fire_i) op_q <= op_i;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      S_INIT: begin
        // clearing pass over the valid bits after reset, no result
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire_i) begin
          cmd_o.load = 1'b1;
          case (op_e'(op_i))
            OP_CLEAR: begin
              cmd_o.clr_start = 1'b1;
              state_d = S_CLR;
            end
            OP_INSERT, OP_LOOKUP: state_d = S_MOD;
            default: state_d = S_FIN;
          endcase
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_done) state_d = S_RD;
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (sts_i.exhaust) begin
          // count the last collision; the slot stays where it is
          cmd_o.adv = 1'b1;
          state_d = S_FIN;
        end else if (sts_i.hit || sts_i.empty) begin
          if (op_q == OP_INSERT && !sts_i.hit && !sts_i.exhaust && sts_i.can_ins) begin
            state_d = S_WR;
          end else begin
            state_d = S_FIN;
          end
        end else begin
          cmd_o.adv = 1'b1;
          state_d = S_RD;
        end
      end
      S_WR: begin
        cmd_o.wr = 1'b1;
        state_d = S_FIN;
      end
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_OUT);
endmodule

/* hdl/oaht_dp.sv */
// Datapath for the hash table core: modulo unit, probe walker, slot memories.
module oaht_dp #(
  parameter int unsigned MaxSlots = oaht_pkg::MaxSlotsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [12:0]              table_size_i,
  input  logic [1:0]               op_i,
  input  logic [oaht_pkg::KeyW-1:0] key_i,
  input  logic [oaht_pkg::ValW-1:0] offset_i,
  input  oaht_pkg::cmd_t           cmd_i,
  output oaht_pkg::sts_t           sts_o,
  output logic [1:0]               status_o,
  output logic [31:0]              value_o,
  output logic [11:0]              slot_o,
  output logic [12:0]              probes_o,
  output logic [12:0]              entries_o
);
  import oaht_pkg::*;

  localparam int unsigned AW = $clog2(MaxSlots);
  localparam int unsigned SW = AW + 1;
  localparam int unsigned ModSteps = KeyW;
  localparam int unsigned MsW = $clog2(ModSteps + 1);

  logic [SW-1:0] m_q;
  logic [1:0] op_q;
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] val_q;

  // restoring modulo, one key bit per cycle
  logic [KeyW-1:0] sh_q;
  logic [SW:0] rem_q;
  logic [MsW-1:0] ms_q;
  logic [SW:0] rem_sh;

  logic [AW-1:0] pos_q;
  logic [SW-1:0] cnt_q;

  logic vld_mem [MaxSlots];
  logic [KeyW-1:0] kmem [MaxSlots];
  logic [ValW-1:0] vmem [MaxSlots];
  logic [KeyW-1:0] rk_q;
  logic [ValW-1:0] rv_q;
  logic rvld_q;

  logic [AW-1:0] clr_q;
  logic [CntW-1:0] ent_q;

  logic [SW-1:0] m_eff;
  logic [SW-1:0] cnt_n;
  logic [SW:0] sum;
  logic [SW:0] sum_m;

  always_comb begin
    m_eff = SW'(table_size_i);
    if (table_size_i == 13'd0) m_eff = SW'(1);
    if (32'(table_size_i) > MaxSlots) begin
      m_eff = SW'(MaxSlots);
    end
  end

  assign rem_sh = {rem_q[SW-1:0], sh_q[KeyW-1]};
  assign cnt_n = cnt_q + SW'(1);
  assign sum = (SW + 1)'(pos_q) + (SW + 1)'(cnt_n);
  assign sum_m = sum - (SW + 1)'(m_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_q <= m_eff;
      op_q <= op_i;
      key_q <= key_i;
      val_q <= offset_i;
      sh_q <= key_i;
      rem_q <= '0;
      cnt_q <= '0;
      pos_q <= '0;
    end
    if (cmd_i.mod_step) begin
      sh_q <= {sh_q[KeyW-2:0], 1'b0};
      if (rem_sh >= (SW + 1)'(m_q)) rem_q <= rem_sh - (SW + 1)'(m_q);
      else rem_q <= rem_sh;
      if (ms_q == MsW'(ModSteps - 1)) begin
        if (rem_sh >= (SW + 1)'(m_q)) pos_q <= AW'(rem_sh - (SW + 1)'(m_q));
        else pos_q <= AW'(rem_sh);
      end
    end
    if (cmd_i.rd) begin
      rk_q <= kmem[pos_q];
      rv_q <= vmem[pos_q];
      rvld_q <= vld_mem[pos_q];
    end
    if (cmd_i.adv) begin
      cnt_q <= cnt_n;
      if (cnt_n < m_q) begin
        // pos and cnt both below m, so one subtract suffices
        if (sum >= (SW + 1)'(m_q)) pos_q <= AW'(sum_m);
        else pos_q <= AW'(sum);
      end
    end
    if (cmd_i.wr) begin
      kmem[pos_q] <= key_q;
      vmem[pos_q] <= val_q;
    end
    if (cmd_i.clr_step) vld_mem[clr_q] <= 1'b0;
    else if (cmd_i.wr) vld_mem[pos_q] <= 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q <= '0;
      clr_q <= '0;
      ent_q <= '0;
      status_o <= ST_OK;
      value_o <= '0;
      slot_o <= '0;
      probes_o <= '0;
      entries_o <= '0;
    end else begin
      if (cmd_i.load) ms_q <= '0;
      else if (cmd_i.mod_step) ms_q <= ms_q + MsW'(1);
      if (cmd_i.clr_start) begin
        clr_q <= '0;
        ent_q <= '0;
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.wr) begin
        ent_q <= ent_q + CntW'(1);
      end
      if (cmd_i.fin) begin
        status_o <= ST_OK;
        value_o <= '0;
        slot_o <= 12'(pos_q);
        probes_o <= 13'(cnt_q);
        entries_o <= ent_q;
        case (op_e'(op_q))
          OP_INSERT: begin
            if (rvld_q && rk_q == key_q && cnt_q < m_q) status_o <= ST_DUP;
            else if (!(cnt_q < SW'(m_q >> 1))) status_o <= ST_GROW;
          end
          OP_LOOKUP: begin
            if (rvld_q && rk_q == key_q && cnt_q < m_q) value_o <= rv_q;
            else status_o <= ST_NFOUND;
          end
          default: begin
            slot_o <= '0;
            probes_o <= '0;
          end
        endcase
      end
    end
  end

  assign sts_o.mod_done = (ms_q == MsW'(ModSteps - 1));
  assign sts_o.hit = rvld_q && (rk_q == key_q);
  assign sts_o.empty = !rvld_q;
  assign sts_o.exhaust = !(cnt_n < m_q) && !(rvld_q && rk_q == key_q) && rvld_q;
  assign sts_o.clr_done = (clr_q == AW'(MaxSlots - 1));
  assign sts_o.can_ins = (cnt_q < SW'(m_q >> 1));
endmodule

/* hdl/open_addressing_hash_table_core.sv */
// Top level of the open-addressing hash table core.
// Stream in one op item (clear, insert, lookup, no-op) on s_axis; one result
// item per op comes out on m_axis. table_size is written through cfg_we_i;
// the user must write it only while the block is idle; the block itself
// does not enforce this. Sizes of 0 act as 1, above MAX_SLOTS as MAX_SLOTS.
// An insert or lookup first runs the bit-serial home-slot modulo, then
// a memory read and a compare for each slot visited on the probe walk, an
// insert write where one is made, then the result is formed and presented.
// Clear walks every valid bit, one per cycle, before its result; a no-op
// only forms and presents its result. One item is in flight at a time.
// Reset zeroes the entry count and loads table_size with 2531, then a
// clearing pass empties the table one slot per cycle; s_axis_tready stays
// low until it is done. The result is held in the output register while
// m_axis_tready is low; no new item is accepted until the result has been
// taken.
module open_addressing_hash_table_core #(
  parameter int unsigned MAX_SLOTS = oaht_pkg::MaxSlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] op, [32:2] key, [64:33] offset, [71:65] zero
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [33:2] value, [45:34] slot, [58:46] probes,
  // [71:59] entries
  output logic [71:0] m_axis_tdata
);
  import oaht_pkg::*;

  logic [12:0] size_q;
  cmd_t cmd;
  sts_t sts;
  logic busy, rv, in_fire;
  logic [1:0] st;
  logic [31:0] val;
  logic [11:0] slot;
  logic [12:0] prb, ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) size_q <= SizeReset;
    else if (cfg_we_i) size_q <= cfg_wdata_i;
  end

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  oaht_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i(in_fire),
    .op_i(s_axis_tdata[1:0]),
    .out_free_i(m_axis_tready),
    .sts_i(sts),
    .cmd_o(cmd),
    .busy_o(busy),
    .res_valid_o(rv)
  );

  oaht_dp #(.MaxSlots(MAX_SLOTS)) u_dp (
    .clk_i, .rst_ni,
    .table_size_i(size_q),
    .op_i(s_axis_tdata[1:0]),
    .key_i(s_axis_tdata[32:2]),
    .offset_i(s_axis_tdata[64:33]),
    .cmd_i(cmd),
    .sts_o(sts),
    .status_o(st),
    .value_o(val),
    .slot_o(slot),
    .probes_o(prb),
    .entries_o(ent)
  );

  assign m_axis_tvalid = rv;
  assign m_axis_tdata = {ent, prb, slot, val, st};

`include "open_addressing_hash_table_core_assert.svh"

  `OAHT_ASSERT_IMP(a_no_accept_busy, m_axis_tvalid, !s_axis_tready)
  `OAHT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `OAHT_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0({cmd.wr, cmd.adv, cmd.rd, cmd.fin}))
endmodule
